### sv/uartrb_pkg.sv
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared types, codes and constants for the transmit and receive ring pair.
// ----------------------------------------------------------------------------
`default_nettype none

package uartrb_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int SIZE_W         = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_SEND    = 2'd1,
    REQ_SERVICE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_SEND,
    OP_SERVICE
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_RESP
  } back_state_e;

  typedef enum logic {
    REG_RX_SIZE = 1'b0,
    REG_TX_SIZE = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] send_byte;
    logic       rx_ready;
    logic [7:0] rx_data;
    logic       tx_ready;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       tx_irq_on;
    logic       rx_dropped;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] send_byte;
    logic       rx_ready;
    logic [7:0] rx_data;
    logic       tx_ready;
  } cmd_t;

endpackage

`default_nettype wire

### sv/uartrb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Up to one write and one read per cycle at a shared address, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uartrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

### sv/uartrb_front.sv
// ----------------------------------------------------------------------------
// UART ring buffer front end
// Accepts request transfers, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uartrb_front
  import uartrb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.send_byte = in_item_i.send_byte;
    cmd_new.rx_ready  = in_item_i.rx_ready;
    cmd_new.rx_data   = in_item_i.rx_data;
    cmd_new.tx_ready  = in_item_i.tx_ready;
    unique case (in_item_i.req_type)
      REQ_READ:    cmd_new.op = OP_READ;
      REQ_SEND:    cmd_new.op = OP_SEND;
      REQ_SERVICE: cmd_new.op = OP_SERVICE;
      default:     cmd_new.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

### sv/uartrb_back.sv
// ----------------------------------------------------------------------------
// UART ring buffer back end
// Executes queued commands against both rings and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module uartrb_back
  import uartrb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SIZE_W-1:0] rx_size_i,
  input  wire logic [SIZE_W-1:0] tx_size_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire cmd_t              cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_item_o
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int EW    = (PTR_W + 1 > SIZE_W) ? PTR_W + 1 : SIZE_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(RING_DEPTH);
  localparam logic [EW-1:0] MIN_E   = EW'(2);

  function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] sz);
    logic [EW-1:0] s;
    s = EW'(sz);
    if (s < MIN_E) begin
      return MIN_E;
    end else if (s > DEPTH_E) begin
      return DEPTH_E;
    end
    return s;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                               input logic [EW-1:0]    eff);
    logic [EW-1:0] n;
    n = EW'(ptr) + EW'(1);
    return (n >= eff) ? '0 : n[PTR_W-1:0];
  endfunction

  back_state_e      state_q, state_d;
  logic [PTR_W-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic [PTR_W-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic             irq_q, irq_d;
  logic [1:0]       pend_status_q, pend_status_d;
  logic             pend_rd_q, pend_rd_d;
  logic             pend_txv_q, pend_txv_d;
  logic             pend_drop_q, pend_drop_d;
  logic             res_valid_q;
  out_item_t        res_q;
  logic             out_free, load_res;

  logic [EW-1:0]    rx_eff, tx_eff;
  logic [PTR_W-1:0] rx_nxt_wr, tx_nxt_wr;
  logic [PTR_W-1:0] rx_addr, tx_addr;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rdata, tx_rdata;

  assign rx_eff    = eff_size(rx_size_i);
  assign tx_eff    = eff_size(tx_size_i);
  assign rx_nxt_wr = advance(rx_wr_q, rx_eff);
  assign tx_nxt_wr = advance(tx_wr_q, tx_eff);
  assign out_free  = !res_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = BK_RESP;
      BK_RESP: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o   = 1'b0;
    load_res      = 1'b0;
    rx_wr_d       = rx_wr_q;
    rx_rd_d       = rx_rd_q;
    tx_wr_d       = tx_wr_q;
    tx_rd_d       = tx_rd_q;
    irq_d         = irq_q;
    pend_status_d = pend_status_q;
    pend_rd_d     = pend_rd_q;
    pend_txv_d    = pend_txv_q;
    pend_drop_d   = pend_drop_q;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    rx_addr       = rx_wr_q;
    tx_addr       = tx_rd_q;
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          pend_status_d = ST_OK;
          pend_rd_d     = 1'b0;
          pend_txv_d    = 1'b0;
          pend_drop_d   = 1'b0;
          case (cmd_i.op)
            OP_READ: begin
              rx_addr = rx_rd_q;
              if (rx_rd_q == rx_wr_q) begin
                pend_status_d = ST_EMPTY;
              end else begin
                rx_re     = 1'b1;
                pend_rd_d = 1'b1;
                rx_rd_d   = advance(rx_rd_q, rx_eff);
              end
            end
            OP_SEND: begin
              tx_addr = tx_wr_q;
              if (tx_nxt_wr == tx_rd_q) begin
                pend_status_d = ST_FULL;
              end else begin
                tx_we   = 1'b1;
                tx_wr_d = tx_nxt_wr;
                irq_d   = 1'b1;
              end
            end
            OP_SERVICE: begin
              if (cmd_i.rx_ready) begin
                if (rx_nxt_wr != rx_rd_q) begin
                  rx_we   = 1'b1;
                  rx_wr_d = rx_nxt_wr;
                end else begin
                  pend_drop_d = 1'b1;
                end
              end
              if (cmd_i.tx_ready) begin
                if (tx_rd_q != tx_wr_q) begin
                  tx_re      = 1'b1;
                  pend_txv_d = 1'b1;
                  tx_rd_d    = advance(tx_rd_q, tx_eff);
                end else begin
                  irq_d = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_RESP: load_res = out_free;
      default: ;
    endcase
  end

  uartrb_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .addr_i (rx_addr),
    .we_i   (rx_we),
    .wdata_i(cmd_i.rx_data),
    .re_i   (rx_re),
    .rdata_o(rx_rdata)
  );

  uartrb_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .addr_i (tx_addr),
    .we_i   (tx_we),
    .wdata_i(cmd_i.send_byte),
    .re_i   (tx_re),
    .rdata_o(tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      irq_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rx_wr_q <= rx_wr_d;
      rx_rd_q <= rx_rd_d;
      tx_wr_q <= tx_wr_d;
      tx_rd_q <= tx_rd_d;
      irq_q   <= irq_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_rd_q     <= pend_rd_d;
    pend_txv_q    <= pend_txv_d;
    pend_drop_q   <= pend_drop_d;
    if (load_res) begin
      res_q.read_data  <= pend_rd_q ? rx_rdata : 8'd0;
      res_q.status     <= pend_status_q;
      res_q.tx_valid   <= pend_txv_q;
      res_q.tx_data    <= pend_txv_q ? tx_rdata : 8'd0;
      res_q.tx_irq_on  <= irq_q;
      res_q.rx_dropped <= pend_drop_q;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

### sv/uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// UART transmit and receive ring buffers
// Request decode and queue in front, ring execution with two RAMs behind.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid_i/ready_o   in_item_i  (in_item_t)
//   result    out        out_valid_o/ready_i  out_item_o (out_item_t)
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// The back end takes one item at a time: it updates the pointers and
// accesses the ring RAM, then registers the result from the RAM read data.
// A two-entry command queue lets requests be taken while the back end is busy.
// A result waiting in the output register stalls the back end, and the
// request channel as well once the command queue is full.
// Reset clears all pointers and the transmit interrupt enable; RAMs are not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_tx_rx_ring_buffers
  import uartrb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [SIZE_W-1:0] rx_size_q, tx_size_q;
  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  reg_index_e        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_e'(paddr[2]);
  assign prdata  = (reg_idx == REG_TX_SIZE) ? 32'(tx_size_q) : 32'(rx_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_size_q <= SIZE_RESET;
      tx_size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_RX_SIZE: rx_size_q <= pwdata[SIZE_W-1:0];
        REG_TX_SIZE: tx_size_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  uartrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  uartrb_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_size_i  (rx_size_q),
    .tx_size_i  (tx_size_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring buffer pair testbench
// Sends application reads, application sends, interrupt-service requests and
// reserved request codes through the request channel. A local model of both
// rings predicts the results, directed rows with their own expected result
// apart, and the result channel is checked in order. A short table of directed
// requests comes first, followed by random phases. Before each size change
// over the APB port, both rings are drained and all results have arrived.
// ----------------------------------------------------------------------------
module testbench;
  import uartrb_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 160;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [8:0] rx_val;
    logic [8:0] tx_val;
    in_item_t   item;
    out_item_t  want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  rx_mem [DEPTH];
  logic [7:0]  tx_mem [DEPTH];
  logic [7:0]  rx_wr, rx_rd, tx_wr, tx_rd;
  logic        irq_en;
  logic [8:0]  rx_len, tx_len;
  out_item_t   reply_q [$];
  bit          quiet = 1'b0;

  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  int unsigned n_empty = 0;
  int unsigned n_full = 0;
  int unsigned n_drop = 0;
  int unsigned n_sent = 0;

  uart_tx_rx_ring_buffers dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] wrap_next(logic [7:0] ptr, logic [8:0] len);
    int lim;
    lim = (len < 2) ? 2 : (len > DEPTH) ? DEPTH : int'(len);
    return (int'(ptr) + 1 >= lim) ? 8'd0 : ptr + 8'd1;
  endfunction

  function automatic out_item_t ring_pair_step(in_item_t it);
    out_item_t  r;
    logic [7:0] nxt;
    r = '0;
    case (it.req_type)
      REQ_READ: begin
        if (rx_rd == rx_wr) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.read_data = rx_mem[rx_rd];
          rx_rd = wrap_next(rx_rd, rx_len);
        end
      end
      REQ_SEND: begin
        nxt = wrap_next(tx_wr, tx_len);
        if (nxt == tx_rd) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          tx_mem[tx_wr] = it.send_byte;
          tx_wr = nxt;
          irq_en = 1'b1;
        end
      end
      REQ_SERVICE: begin
        if (it.rx_ready) begin
          nxt = wrap_next(rx_wr, rx_len);
          if (nxt != rx_rd) begin
            rx_mem[rx_wr] = it.rx_data;
            rx_wr = nxt;
          end else begin
            r.rx_dropped = 1'b1;
            n_drop++;
          end
        end
        if (it.tx_ready) begin
          if (tx_rd != tx_wr) begin
            r.tx_valid = 1'b1;
            r.tx_data = tx_mem[tx_rd];
            tx_rd = wrap_next(tx_rd, tx_len);
            n_sent++;
          end else begin
            irq_en = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.tx_irq_on = irq_en;
    return r;
  endfunction

  function automatic in_item_t req(logic [1:0] kind, logic [7:0] sb, logic rr,
                                   logic [7:0] rd, logic tr);
    return {kind, sb, rr, rd, tr};
  endfunction

  function automatic out_item_t rsp(logic [7:0] rd, logic [1:0] st, logic tv,
                                    logic [7:0] td, logic irq, logic drop);
    return {rd, st, tv, td, irq, drop};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd3;
      3: return 9'd256;
      4: return 9'($urandom_range(257, 511));
      5: return 9'($urandom_range(17, 255));
      default: return 9'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic in_item_t random_request(int w_read, int w_send, int p_rx, int p_tx);
    in_item_t it;
    int       r;
    it = 20'($urandom());
    r = $urandom_range(0, 99);
    if (r < 3) it.req_type = REQ_RESERVED;
    else if (r < 3 + w_read) it.req_type = REQ_READ;
    else if (r < 3 + w_read + w_send) it.req_type = REQ_SEND;
    else it.req_type = REQ_SERVICE;
    it.rx_ready = ($urandom_range(0, 99) < p_rx);
    it.tx_ready = ($urandom_range(0, 99) < p_tx);
    return it;
  endfunction

  task automatic issue_request(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = ring_pair_step(it);
    reply_q.push_back(typed ? want : predicted);
    n_items++;
  endtask

  task automatic drain_rings();
    in_item_t it;
    while (rx_rd != rx_wr) begin
      it = 20'($urandom());
      it.req_type = REQ_READ;
      issue_request(it, 1'b0, '0);
    end
    while (tx_rd != tx_wr) begin
      it = 20'($urandom());
      it.req_type = REQ_SERVICE;
      it.rx_ready = 1'b0;
      it.tx_ready = 1'b1;
      issue_request(it, 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [8:0] val);
    logic [31:0] word;
    word = ($urandom() & 32'hFFFF_FE00) | {23'd0, val};
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {23'd0, val}) begin
      errors++;
      $display("%0t ns: register %0d read back, expected 0x%0h, got 0x%0h",
               $time, idx, val, prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sizes(logic [8:0] rx_val, logic [8:0] tx_val);
    drain_rings();
    write_reg(REG_RX_SIZE, rx_val);
    write_reg(REG_TX_SIZE, tx_val);
    rx_len = rx_val;
    tx_len = tx_val;
    n_settings++;
  endtask

  task automatic report(string field, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
    end
  endtask

  task automatic check_reply(out_item_t want, out_item_t seen);
    report("read_data", want.read_data, seen.read_data);
    report("status", want.status, seen.status);
    report("tx_valid", want.tx_valid, seen.tx_valid);
    report("tx_data", want.tx_data, seen.tx_data);
    report("tx_irq_on", want.tx_irq_on, seen.tx_irq_on);
    report("rx_dropped", want.rx_dropped, seen.rx_dropped);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t ns: result 0x%0h with nothing expected", $time, out_item_o);
      end else begin
        check_reply(reply_q.pop_front(), out_item_o);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        hold = gap_len();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    plan_row_t  plan [$];
    int         w_read, w_send, p_rx, p_tx;
    logic [8:0] rx_pick, tx_pick;
    in_valid_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_wr = '0;
    rx_rd = '0;
    tx_wr = '0;
    tx_rd = '0;
    irq_en = 1'b0;
    rx_len = SIZE_RESET;
    tx_len = SIZE_RESET;

    plan.push_back({ROW_TYPED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0),
                    rsp(8'h00, ST_EMPTY, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_RESERVED, 8'hFF, 1'b1, 8'hFF, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SEND, 8'hFF, 1'b0, 8'h00, 1'b0),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SEND, 8'h00, 1'b1, 8'hFF, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_RESERVED, 8'h00, 1'b0, 8'h00, 1'b0),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b1, 8'hFF, 1'b1),
                    rsp(8'h00, ST_OK, 1'b1, 8'hFF, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'hFF, 1'b1, 8'h00, 1'b1),
                    rsp(8'h00, ST_OK, 1'b1, 8'h00, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b1, 8'hA5, 1'b0),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0),
                    rsp(8'hFF, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_READ, 8'hFF, 1'b1, 8'hFF, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0),
                    rsp(8'hA5, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0),
                    rsp(8'h00, ST_EMPTY, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SEND, 8'h5A, 1'b0, 8'h00, 1'b0),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1),
                    rsp(8'h00, ST_OK, 1'b1, 8'h5A, 1'b1, 1'b0)});
    plan.push_back({ROW_TYPED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1),
                    rsp(8'h00, ST_OK, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({ROW_CFG, 9'd0, 9'd1, 20'd0, 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SEND, 8'h11, 1'b0, 8'h00, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b1, 8'h22, 1'b1), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SEND, 8'h33, 1'b0, 8'h00, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SEND, 8'h44, 1'b0, 8'h00, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b1, 8'h55, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b1, 8'h66, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0), 21'd0});
    plan.push_back({ROW_PRED, 18'd0, req(REQ_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1), 21'd0});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: set_sizes(plan[i].rx_val, plan[i].tx_val);
        default: issue_request(plan[i].item, plan[i].kind == ROW_TYPED, plan[i].want);
      endcase
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          rx_pick = 9'd256;
          tx_pick = 9'd2;
        end
        1: begin
          rx_pick = 9'd2;
          tx_pick = 9'd256;
        end
        2: begin
          rx_pick = 9'd511;
          tx_pick = 9'd0;
        end
        default: begin
          rx_pick = pick_size();
          tx_pick = pick_size();
        end
      endcase
      set_sizes(rx_pick, tx_pick);
      w_read = $urandom_range(10, 45);
      w_send = $urandom_range(10, 45);
      p_rx = $urandom_range(10, 90);
      p_tx = $urandom_range(10, 90);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) == 0) quiet = !quiet;
        issue_request(random_request(w_read, w_send, p_rx, p_tx), 1'b0, '0);
      end
    end

    quiet = 1'b0;
    drain_rings();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests over %0d ring size settings.", n_items, n_settings);
    $display("Saw %0d empty reads, %0d full sends, %0d dropped receive bytes, %0d bytes sent.",
             n_empty, n_full, n_drop, n_sent);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/uartrb_pkg.sv
sv/uartrb_ram.sv
sv/uartrb_front.sv
sv/uartrb_back.sv
sv/uart_tx_rx_ring_buffers.sv
dv/testbench.sv
